@@ rtl/tqla_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the tabular Q-learning agent.
// No dependencies; the channel interfaces and the top level import it.

package tqla_pkg;

	// Default table geometry
	localparam int NUM_STATES_DEF  = 256;
	localparam int NUM_ACTIONS_DEF = 4;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT          = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_THRESHOLD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_STATE       = 2'd3;

	localparam logic [15:0] LEARNING_RATE_RST     = 16'd6554;
	localparam logic [15:0] DISCOUNT_RST          = 16'd58982;
	localparam logic [15:0] EXPLORE_THRESHOLD_RST = 16'd6554;
	localparam logic [7:0]  START_STATE_RST       = 8'd0;

	// Operation codes
	localparam logic [1:0] OP_CHOOSE  = 2'd0;
	localparam logic [1:0] OP_UPDATE  = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	typedef struct packed {
		logic [1:0]         operation;
		logic [15:0]        random_draw;
		logic [1:0]         random_action;
		logic [7:0]         next_state;
		logic signed [31:0] reward;
	} tqla_cmd_t;

	typedef struct packed {
		logic [1:0]         chosen_action;
		logic               explored;
		logic signed [31:0] new_q_value;
		logic signed [31:0] best_next_value;
		logic [7:0]         present_state;
	} tqla_res_t;

endpackage

`default_nettype wire

@@ rtl/tqla_cmd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel that carries command transactions into the agent.
// Depends on tqla_pkg for the payload type.

interface tqla_cmd_if;
	import tqla_pkg::*;

	logic      valid;
	logic      ready;
	tqla_cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/tqla_res_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel that carries result transactions out of the agent.
// Depends on tqla_pkg for the payload type.

interface tqla_res_if;
	import tqla_pkg::*;

	logic      valid;
	logic      ready;
	tqla_res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/tabular_q_learning_agent.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Tabular Q-learning agent: Q-table memory, row scan, shared multiplier.
// Depends on tqla_pkg, tqla_cmd_if and tqla_res_if.

// After reset the agent sweeps every entry of the Q-table to zero, one entry a
// cycle; commands wait, but configuration writes are taken. It then works on
// one command at a time.
// The table has a single read port, so a row is scanned one entry a cycle,
// and one 17x34 multiplier is shared by the two products of an update.
// Per command: an explore choice, a restart or an unknown code goes straight
// to the result stage; a greedy choice scans the present row; an update scans
// the next-state row, then steps through MUL_DISC, ERR, MUL_STEP, SUM and WRITE.
// A finished result sits in an output register; the next command is taken
// while it waits, and a later result waits until that register drains.

module tabular_q_learning_agent #(
	parameter int NUM_STATES  = tqla_pkg::NUM_STATES_DEF,
	parameter int NUM_ACTIONS = tqla_pkg::NUM_ACTIONS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	tqla_cmd_if.sink                            cmd,
	tqla_res_if.source                          res,
	input  wire logic                           cfg_wr_en,
	input  wire logic [tqla_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tqla_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tqla_pkg::*;

	localparam int SW    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
	localparam int AW    = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
	localparam int CW    = $clog2(NUM_ACTIONS + 1);
	localparam int DEPTH = NUM_STATES * NUM_ACTIONS;
	localparam int DW    = $clog2(DEPTH);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_MUL_DISC,
		ST_ERR,
		ST_MUL_STEP,
		ST_SUM,
		ST_WRITE,
		ST_DONE
	} state_t;

	// Reduce an 8-bit state index modulo NUM_STATES by restoring subtraction
	function automatic logic [SW-1:0] state_mod(input logic [7:0] v);
		logic [20:0] r;
		r = 21'(v);
		for (int i = 7; i >= 0; i--) begin
			if (r >= (21'(NUM_STATES) << i)) begin
				r = r - (21'(NUM_STATES) << i);
			end
		end
		return SW'(r);
	endfunction

	function automatic logic [AW-1:0] action_mod(input logic [1:0] v);
		logic [6:0] r;
		r = 7'(v);
		if (r >= 7'(NUM_ACTIONS)) begin
			r = r - 7'(NUM_ACTIONS);
		end
		return AW'(r);
	endfunction

	// Configuration registers
	logic [15:0] learning_rate_q;
	logic [15:0] discount_q;
	logic [15:0] explore_threshold_q;
	logic [7:0]  start_state_q;

	// Control state
	state_t          state_q;
	logic [DW-1:0]   clr_q;
	logic [CW-1:0]   cnt_q;
	logic [SW-1:0]   cur_q;
	logic [AW-1:0]   last_q;
	logic [1:0]      op_q;
	logic            rd_valid_s1;
	logic            rd_old_s1;
	logic [AW-1:0]   rd_act_s1;
	logic            excl_vld_q;
	logic            res_valid_q;
	tqla_res_t       res_data_q;

	// Datapath registers
	logic [DW-1:0]        base_q;
	logic [DW-1:0]        wr_addr_q;
	logic [SW-1:0]        sn_q;
	logic                 same_row_q;
	logic signed [31:0]   reward_q;
	logic signed [31:0]   rd_data_q;
	logic signed [31:0]   old_q;
	logic signed [31:0]   max_q;
	logic [AW-1:0]        arg_q;
	logic signed [31:0]   excl_q;
	logic signed [50:0]   prod_q;
	logic signed [33:0]   err_q;
	logic signed [31:0]   newq_q;
	tqla_res_t            pend_q;

	// Q-table
	logic signed [31:0] mem [DEPTH];

	// Combinational signals
	logic                 accept;
	logic                 issue;
	logic                 rd_en;
	logic [DW-1:0]        rd_addr;
	logic [DW-1:0]        old_addr_c;
	logic                 wr_en;
	logic [DW-1:0]        wr_addr;
	logic signed [31:0]   wr_data;
	logic                 row_hit;
	logic                 take_c;
	logic                 scan_done;
	logic                 excl_take;
	logic [AW-1:0]        arg_next_c;
	logic [AW-1:0]        pend_q_arg;
	logic signed [16:0]   mul_a;
	logic signed [33:0]   mul_b;
	logic signed [50:0]   mul_c;
	logic signed [31:0]   disc_c;
	logic signed [35:0]   sum_c;
	logic signed [31:0]   sat_c;
	logic signed [31:0]   best_c;
	logic                 out_free;

	assign accept     = cmd.valid && cmd.ready;
	assign cmd.ready  = (state_q == ST_IDLE);
	assign res.valid  = res_valid_q;
	assign res.data   = res_data_q;
	assign out_free   = !res_valid_q || res.ready;

	assign issue      = (state_q == ST_SCAN) && (cnt_q < CW'(NUM_ACTIONS));
	assign old_addr_c = DW'(cur_q) * DW'(NUM_ACTIONS) + DW'(last_q);
	assign rd_en      = issue || (accept && cmd.data.operation == OP_UPDATE);
	assign rd_addr    = issue ? (base_q + DW'(cnt_q)) : old_addr_c;

	// Row scan: strict compare keeps the lowest index on ties
	assign row_hit    = rd_valid_s1 && !rd_old_s1;
	assign take_c     = (rd_act_s1 == '0) || (rd_data_q > max_q);
	assign arg_next_c = take_c ? rd_act_s1 : pend_q_arg;
	assign scan_done  = row_hit && (rd_act_s1 == AW'(NUM_ACTIONS - 1));
	// Running maximum of the next-state row without the entry being updated
	assign excl_take  = row_hit && !(same_row_q && rd_act_s1 == last_q)
		&& (!excl_vld_q || rd_data_q > excl_q);

	assign pend_q_arg = arg_q;

	// Shared multiplier: gamma*max first, then alpha*error
	always_comb begin
		if (state_q == ST_MUL_STEP) begin
			mul_a = $signed({1'b0, learning_rate_q});
			mul_b = err_q;
		end else begin
			mul_a = $signed({1'b0, discount_q});
			mul_b = 34'(max_q);
		end
		mul_c = mul_a * mul_b;
	end

	// Arithmetic shift right by 16 floors toward minus infinity
	assign disc_c = prod_q[47:16];
	assign sum_c  = 36'(old_q) + 36'($signed(prod_q[50:16]));

	always_comb begin
		if (sum_c[35:31] == '0 || sum_c[35:31] == '1) begin
			sat_c = sum_c[31:0];
		end else if (sum_c[35]) begin
			sat_c = 32'sh8000_0000;
		end else begin
			sat_c = 32'sh7fff_ffff;
		end
	end

	always_comb begin
		if (!same_row_q) begin
			best_c = max_q;
		end else if (excl_vld_q && excl_q > newq_q) begin
			best_c = excl_q;
		end else begin
			best_c = newq_q;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wr_addr_q;
		wr_data = newq_q;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			ST_WRITE: begin
				wr_en = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learning_rate_q     <= LEARNING_RATE_RST;
			discount_q          <= DISCOUNT_RST;
			explore_threshold_q <= EXPLORE_THRESHOLD_RST;
			start_state_q       <= START_STATE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_LEARNING_RATE:     learning_rate_q <= cfg_data;
				CFG_DISCOUNT:          discount_q <= cfg_data;
				CFG_EXPLORE_THRESHOLD: explore_threshold_q <= cfg_data;
				CFG_START_STATE:       start_state_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sn_q       <= state_mod(cmd.data.next_state);
			same_row_q <= (state_mod(cmd.data.next_state) == cur_q);
			reward_q   <= cmd.data.reward;
			wr_addr_q  <= old_addr_c;
			if (cmd.data.operation == OP_UPDATE) begin
				base_q <= DW'(state_mod(cmd.data.next_state)) * DW'(NUM_ACTIONS);
			end else begin
				base_q <= DW'(cur_q) * DW'(NUM_ACTIONS);
			end
		end
		if (rd_valid_s1 && rd_old_s1) begin
			old_q <= rd_data_q;
		end
		if (row_hit && take_c) begin
			max_q <= rd_data_q;
			arg_q <= rd_act_s1;
		end
		if (excl_take) begin
			excl_q <= rd_data_q;
		end
		if (state_q == ST_MUL_DISC || state_q == ST_MUL_STEP) begin
			prod_q <= mul_c;
		end
		if (state_q == ST_ERR) begin
			err_q <= 34'(reward_q) + 34'(disc_c) - 34'(old_q);
		end
		if (state_q == ST_SUM) begin
			newq_q <= sat_c;
		end

		// Build the result of the transaction in flight
		if (accept) begin
			pend_q.chosen_action   <= 2'(last_q);
			pend_q.explored        <= 1'b0;
			pend_q.new_q_value     <= '0;
			pend_q.best_next_value <= '0;
			pend_q.present_state   <= 8'(cur_q);
			case (cmd.data.operation)
				OP_CHOOSE: begin
					if (cmd.data.random_draw <= explore_threshold_q) begin
						pend_q.chosen_action <= 2'(action_mod(cmd.data.random_action));
						pend_q.explored      <= 1'b1;
					end
				end
				OP_RESTART: begin
					pend_q.present_state <= 8'(state_mod(start_state_q));
				end
				default: begin
				end
			endcase
		end else if (state_q == ST_SCAN && scan_done && op_q == OP_CHOOSE) begin
			pend_q.chosen_action <= 2'(arg_next_c);
		end else if (state_q == ST_WRITE) begin
			pend_q.new_q_value     <= newq_q;
			pend_q.best_next_value <= best_c;
			pend_q.present_state   <= 8'(sn_q);
		end
	end

	// Sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			cur_q       <= '0;
			last_q      <= '0;
			op_q        <= OP_CHOOSE;
			rd_valid_s1 <= 1'b0;
			rd_old_s1   <= 1'b0;
			rd_act_s1   <= '0;
			excl_vld_q  <= 1'b0;
			res_valid_q <= 1'b0;
			res_data_q  <= '0;
		end else begin
			rd_valid_s1 <= rd_en;
			rd_old_s1   <= !issue;
			rd_act_s1   <= AW'(cnt_q);
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (excl_take) begin
				excl_vld_q <= 1'b1;
			end
			if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == DW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						op_q       <= cmd.data.operation;
						cnt_q      <= '0;
						excl_vld_q <= 1'b0;
						state_q    <= ST_DONE;
						case (cmd.data.operation)
							OP_CHOOSE: begin
								if (cmd.data.random_draw > explore_threshold_q) begin
									state_q <= ST_SCAN;
								end else begin
									last_q <= action_mod(cmd.data.random_action);
								end
							end
							OP_UPDATE: begin
								state_q <= ST_SCAN;
							end
							OP_RESTART: begin
								cur_q <= state_mod(start_state_q);
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						if (op_q == OP_CHOOSE) begin
							last_q  <= arg_next_c;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_MUL_DISC;
						end
					end
				end
				ST_MUL_DISC: state_q <= ST_ERR;
				ST_ERR:      state_q <= ST_MUL_STEP;
				ST_MUL_STEP: state_q <= ST_SUM;
				ST_SUM:      state_q <= ST_WRITE;
				ST_WRITE: begin
					cur_q   <= sn_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// Hold until the output register drains
					if (out_free) begin
						res_data_q  <= pend_q;
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ dv/tb_tabular_q_learning_agent.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the tabular Q-learning agent: directed corner items,
// then random episodes under several register settings, each result checked against
// a local Q-table predictor. Depends on tqla_pkg, tqla_cmd_if, tqla_res_if and the RTL.

module tb_tabular_q_learning_agent;
	import tqla_pkg::*;

	localparam int STATES        = NUM_STATES_DEF;
	localparam int ACTIONS       = NUM_ACTIONS_DEF;
	localparam logic [1:0] OP_UNKNOWN = 2'd3;
	localparam int SETTLE_CYCLES = ACTIONS + 16;
	localparam int PHASE_ITEMS   = 290;

	localparam logic signed [31:0] REWARD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] REWARD_MIN = 32'sh8000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tqla_cmd_if cmd_ch();
	tqla_res_if res_ch();

	tabular_q_learning_agent dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predicted agent state
	logic signed [31:0] q_table [STATES*ACTIONS];
	logic [7:0]  agent_state;
	logic [1:0]  agent_action;
	logic [15:0] alpha_q;
	logic [15:0] gamma_q;
	logic [15:0] epsilon_q;
	logic [7:0]  start_q;

	tqla_res_t expected_results[$];
	int fail_count = 0;
	bit idle_en = 1'b1;

	always #1 clk = ~clk;

	function automatic logic [1:0] greedy_action(input logic [7:0] s);
		logic [1:0] best;
		best = 2'd0;
		for (int a = 1; a < ACTIONS; a++)
			if (q_table[int'(s)*ACTIONS + a] > q_table[int'(s)*ACTIONS + int'(best)])
				best = a[1:0];
		return best;
	endfunction

	function automatic logic signed [31:0] row_peak(input logic [7:0] s);
		return q_table[int'(s)*ACTIONS + int'(greedy_action(s))];
	endfunction

	// Apply one command to the predicted state and return the result it should produce.
	function automatic tqla_res_t agent_step(input tqla_cmd_t c);
		tqla_res_t r;
		int slot;
		logic signed [63:0] prior, peak, alpha64, gamma64, rew64;
		logic signed [63:0] discounted, td_error, delta, updated;
		r = '0;
		case (c.operation)
			OP_CHOOSE: begin
				if (c.random_draw > epsilon_q) begin
					agent_action = greedy_action(agent_state);
				end else begin
					agent_action = c.random_action;
					r.explored = 1'b1;
				end
			end
			OP_UPDATE: begin
				slot = int'(agent_state)*ACTIONS + int'(agent_action);
				prior = q_table[slot];
				peak = row_peak(c.next_state);
				alpha64 = {48'd0, alpha_q};
				gamma64 = {48'd0, gamma_q};
				rew64 = $signed(c.reward);
				// floor by 16 bits: arithmetic shift of the exact product
				discounted = (gamma64 * peak) >>> 16;
				td_error = rew64 + discounted - prior;
				delta = (alpha64 * td_error) >>> 16;
				updated = prior + delta;
				if (updated > 64'sd2147483647)
					updated = 64'sd2147483647;
				else if (updated < -64'sd2147483648)
					updated = -64'sd2147483648;
				q_table[slot] = updated[31:0];
				r.new_q_value = updated[31:0];
				r.best_next_value = row_peak(c.next_state);
				agent_state = c.next_state;
			end
			OP_RESTART: begin
				agent_state = start_q;
			end
			default: begin
			end
		endcase
		r.chosen_action = agent_action;
		r.present_state = agent_state;
		return r;
	endfunction

	function automatic tqla_cmd_t make_cmd(input logic [1:0] op, input logic [15:0] draw,
			input logic [1:0] ract, input logic [7:0] nxt, input logic signed [31:0] rew);
		tqla_cmd_t c;
		c.operation = op;
		c.random_draw = draw;
		c.random_action = ract;
		c.next_state = nxt;
		c.reward = rew;
		return c;
	endfunction

	function automatic logic [7:0] pick_state();
		// mostly a handful of states so rows fill up and ties get broken
		if ($urandom_range(0, 3) != 0)
			return 8'($urandom_range(0, 7));
		return 8'($urandom_range(0, STATES - 1));
	endfunction

	function automatic logic [15:0] pick_draw();
		if ($urandom_range(0, 4) == 0)
			return epsilon_q + 16'($urandom_range(0, 4)) - 16'd2;
		return 16'($urandom);
	endfunction

	function automatic logic signed [31:0] pick_reward();
		case ($urandom_range(0, 7))
			0, 1, 2: return $signed(32'($urandom_range(0, 32'h0006_0000))) - 32'sh0003_0000;
			3:       return $signed(32'($urandom_range(0, 32'h7FFF_FFFF))) >>> 1;
			4:       return $signed(32'($urandom));
			5:       return REWARD_MAX;
			6:       return REWARD_MIN;
			default: return 32'sd0;
		endcase
	endfunction

	function automatic tqla_cmd_t random_cmd(input logic [1:0] op);
		return make_cmd(op, pick_draw(), 2'($urandom), pick_state(), pick_reward());
	endfunction

	function automatic logic [1:0] random_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return OP_CHOOSE;
		if (r < 85)
			return OP_UPDATE;
		if (r < 95)
			return OP_RESTART;
		return OP_UNKNOWN;
	endfunction

	// Call at a falling edge. Leaves valid high; the caller drops it via wait_idle.
	task automatic send_cmd(input tqla_cmd_t c);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= c;
		do @(posedge clk); while (!cmd_ch.ready);
		expected_results.push_back(agent_step(c));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
		case (idx)
			CFG_LEARNING_RATE:     alpha_q = val;
			CFG_DISCOUNT:          gamma_q = val;
			CFG_EXPLORE_THRESHOLD: epsilon_q = val;
			CFG_START_STATE:       start_q = val[7:0];
			default: begin
			end
		endcase
	endtask

	task automatic set_config(input logic [15:0] alpha, input logic [15:0] gamma,
			input logic [15:0] epsilon, input logic [15:0] start);
		write_reg(CFG_LEARNING_RATE, alpha);
		write_reg(CFG_DISCOUNT, gamma);
		write_reg(CFG_EXPLORE_THRESHOLD, epsilon);
		write_reg(CFG_START_STATE, start);
	endtask

	// Mostly choose/update pairs, with single noise items in between.
	task automatic run_episodes(input int n);
		int sent;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 9) < 8) begin
				send_cmd(random_cmd(OP_CHOOSE));
				send_cmd(random_cmd(OP_UPDATE));
				sent += 2;
			end else begin
				send_cmd(random_cmd(random_op()));
				sent++;
			end
		end
	endtask

	task automatic test_reset_values();
		send_cmd(make_cmd(OP_UPDATE, 16'h0000, 2'd0, 8'd3, 32'sh0001_0000));
		send_cmd(make_cmd(OP_CHOOSE, 16'h0000, 2'd3, 8'd0, 32'sd0));
		send_cmd(make_cmd(OP_CHOOSE, 16'hFFFF, 2'd1, 8'd0, 32'sd0));
		send_cmd(make_cmd(OP_CHOOSE, EXPLORE_THRESHOLD_RST, 2'd2, 8'd0, 32'sd0));
		send_cmd(make_cmd(OP_CHOOSE, EXPLORE_THRESHOLD_RST + 16'd1, 2'd1, 8'd0, 32'sd0));
		send_cmd(make_cmd(OP_UPDATE, 16'h0000, 2'd0, 8'd3, 32'sd0));
		send_cmd(make_cmd(OP_RESTART, 16'hFFFF, 2'd3, 8'hFF, 32'sd0));
		send_cmd(make_cmd(OP_UNKNOWN, 16'hFFFF, 2'd3, 8'hFF, 32'shFFFF_FFFF));
		wait_idle();
	endtask

	task automatic test_saturation();
		// epsilon 0: draw 0 explores, any nonzero draw is greedy
		set_config(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
		send_cmd(make_cmd(OP_RESTART, 16'h0000, 2'd0, 8'd0, 32'sd0));
		send_cmd(make_cmd(OP_CHOOSE, 16'h0000, 2'd1, 8'd0, 32'sd0));
		send_cmd(make_cmd(OP_UPDATE, 16'h0000, 2'd0, 8'hFF, REWARD_MAX));
		send_cmd(make_cmd(OP_UPDATE, 16'h0000, 2'd0, 8'hFF, REWARD_MAX));
		send_cmd(make_cmd(OP_CHOOSE, 16'h0001, 2'd0, 8'd0, 32'sd0));
		send_cmd(make_cmd(OP_UPDATE, 16'h0000, 2'd0, 8'd7, 32'sd0));
		// drive every entry of row 7 to the bottom, then push below the range
		for (int a = 0; a < ACTIONS; a++) begin
			send_cmd(make_cmd(OP_CHOOSE, 16'h0000, a[1:0], 8'd0, 32'sd0));
			send_cmd(make_cmd(OP_UPDATE, 16'h0000, 2'd0, 8'd7, REWARD_MIN));
		end
		send_cmd(make_cmd(OP_CHOOSE, 16'h0000, 2'd0, 8'd0, 32'sd0));
		send_cmd(make_cmd(OP_UPDATE, 16'hFFFF, 2'd3, 8'd7, REWARD_MIN));
		send_cmd(make_cmd(OP_CHOOSE, 16'hFFFF, 2'd0, 8'd0, 32'sd0));
		send_cmd(make_cmd(OP_UNKNOWN, 16'h0000, 2'd0, 8'd0, 32'sd0));
		wait_idle();
	endtask

	task automatic test_random_settings();
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: set_config(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
						16'($urandom), 16'($urandom_range(0, 7)));
				1: set_config(16'd1, 16'd1, 16'hFFFF, 16'($urandom));
				2: set_config(16'hFFFF, 16'hFFFF, 16'h0000, 16'($urandom_range(0, 7)));
				default: set_config(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
						16'($urandom_range(16'h4000, 16'hC000)), 16'($urandom));
			endcase
			run_episodes(PHASE_ITEMS);
			wait_idle();
		end
	endtask

	task automatic test_drain_pause();
		set_config(LEARNING_RATE_RST, DISCOUNT_RST, EXPLORE_THRESHOLD_RST, 16'd2);
		run_episodes(40);
		// hold the sender until every pending result has drained
		cmd_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		run_episodes(40);
		wait_idle();
	endtask

	task automatic test_back_to_back();
		idle_en = 1'b0;
		set_config(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
				16'($urandom), 16'($urandom_range(0, 7)));
		run_episodes(200);
		wait_idle();
	endtask

	always begin
		@(negedge clk);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			res_ch.ready <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		res_ch.ready <= 1'b1;
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : check_results
		tqla_res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_results.size() == 0) begin
				$error("result transaction with nothing expected");
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("chosen_action", 32'(want.chosen_action), 32'(res_ch.data.chosen_action));
				check_field("explored", 32'(want.explored), 32'(res_ch.data.explored));
				check_field("new_q_value", want.new_q_value, res_ch.data.new_q_value);
				check_field("best_next_value", want.best_next_value, res_ch.data.best_next_value);
				check_field("present_state", 32'(want.present_state), 32'(res_ch.data.present_state));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("FAIL tabular_q_learning_agent");
		$finish;
	end

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		res_ch.ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		foreach (q_table[i])
			q_table[i] = '0;
		agent_state = '0;
		agent_action = '0;
		alpha_q = LEARNING_RATE_RST;
		gamma_q = DISCOUNT_RST;
		epsilon_q = EXPLORE_THRESHOLD_RST;
		start_q = START_STATE_RST;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_values();
		test_saturation();
		test_random_settings();
		test_drain_pause();
		test_back_to_back();

		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("PASS tabular_q_learning_agent");
		else
			$display("FAIL tabular_q_learning_agent");
		$finish;
	end

endmodule

@@ files.f @@
rtl/tqla_pkg.sv
rtl/tqla_cmd_if.sv
rtl/tqla_res_if.sv
rtl/tabular_q_learning_agent.sv
dv/tb_tabular_q_learning_agent.sv
